@@ hdl/uncp_pkg.sv @@
`timescale 1ns / 1ps

package uncp_pkg;

    localparam int unsigned NUM_COMP     = 3;
    localparam int unsigned COORD_W      = 16;
    localparam int unsigned OUT_W        = 16;
    localparam int unsigned PROD_W       = 2 * COORD_W;
    localparam int unsigned CROSS_W      = PROD_W + 1;
    localparam int unsigned SQ_W         = 64;
    localparam int unsigned QUO_W        = 31;
    localparam int unsigned ROOT_W       = QUO_W + 1;
    localparam int unsigned FRONT_STAGES = 4;
    localparam int unsigned DIV_STAGES   = QUO_W;
    localparam int unsigned SQRT_STAGES  = ROOT_W / 2;
    localparam int unsigned IN_DATA_W    = 2 * NUM_COMP * COORD_W;
    localparam int unsigned OUT_DATA_W   = NUM_COMP * OUT_W;

    typedef logic signed [COORD_W-1:0] t_coord;

    // per component: running remainder and quotient bits; shared squared magnitude
    typedef struct packed {
        logic [NUM_COMP-1:0][SQ_W-1:0]  rem;
        logic [NUM_COMP-1:0][QUO_W-1:0] quo;
        logic [SQ_W-1:0]                sum;
        logic [NUM_COMP-1:0]            neg;
        logic                           degen;
    } t_div_item;

    typedef struct packed {
        logic [NUM_COMP-1:0][QUO_W-1:0]  op;
        logic [NUM_COMP-1:0][ROOT_W-1:0] root;
        logic [NUM_COMP-1:0]             neg;
        logic                            degen;
    } t_sqrt_item;

endpackage

@@ hdl/unit_normal_cross_product_core.sv @@
// Unit normal of two 3D vectors: n = (a x b) / |a x b|, in signed Q1.14.
// Slave stream: one beat carries a_x, a_y, a_z, b_x, b_y, b_z (signed Q3.12)
// in tdata, 16 bits each, a_x in the lowest bits.
// Master stream: one beat per input beat, in order; tdata holds n_x, n_y, n_z
// (16 bits each, n_x lowest), tuser is the degenerate flag (cross product
// zero, normal forced to zero).
// Each component is round-to-nearest of 16384*|c|/sqrt(S), exact: the core
// divides c^2 * 2^30 by S, takes the integer square root and halves it with
// rounding.
// Pipeline: 4 product/square stages, 31 divider stages, one per quotient
// bit, 16 square-root stages and one output register. Throughput: one beat
// per cycle while the master side does not stall.
// Every stage has its own valid bit and loads when it is empty or the stage
// after it moves, so a stall on the master side fills bubbles first and only
// then drops s_axis tready; nothing is lost or repeated.
// Reset (synchronous, active low) empties all stages; data registers are not reset.
`timescale 1ns / 1ps

module unit_normal_cross_product_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z
    input  logic [uncp_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // n_x, n_y, n_z
    output logic [uncp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // degenerate
    output logic                             o_m_axis_tuser
);

    logic                 w_fr_valid;
    logic                 w_fr_ready;
    uncp_pkg::t_div_item  w_fr_item;
    logic                 w_dv_valid;
    logic                 w_dv_ready;
    uncp_pkg::t_div_item  w_dv_item;
    logic                 w_sq_valid;
    logic                 w_sq_ready;
    uncp_pkg::t_sqrt_item w_sq_item;

    logic                                r_out_v;
    logic [uncp_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic                                r_out_degen;
    logic [uncp_pkg::OUT_DATA_W-1:0]     n_out_data;
    logic [uncp_pkg::OUT_W:0]            w_rnd [uncp_pkg::NUM_COMP];
    logic [uncp_pkg::OUT_W-1:0]          w_mag [uncp_pkg::NUM_COMP];

    uncp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_item  (w_fr_item)
    );

    uncp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_item  (w_fr_item),
        .o_valid (w_dv_valid),
        .i_ready (w_dv_ready),
        .o_item  (w_dv_item)
    );

    uncp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dv_valid),
        .o_ready (w_dv_ready),
        .i_item  (w_dv_item),
        .o_valid (w_sq_valid),
        .i_ready (w_sq_ready),
        .o_item  (w_sq_item)
    );

    assign w_sq_ready = !r_out_v | i_m_axis_tready;

    // root = floor(2*16384*|c|/sqrt(S)); (root + 1) / 2 rounds half away from zero
    always_comb begin
        for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
            w_rnd[i] = {1'b0, w_sq_item.root[i][uncp_pkg::OUT_W-1:0]} +
                       (uncp_pkg::OUT_W + 1)'(1);
            w_mag[i] = w_rnd[i][uncp_pkg::OUT_W:1];
            if (w_sq_item.degen) begin
                n_out_data[i*uncp_pkg::OUT_W +: uncp_pkg::OUT_W] = '0;
            end else if (w_sq_item.neg[i]) begin
                n_out_data[i*uncp_pkg::OUT_W +: uncp_pkg::OUT_W] = -w_mag[i];
            end else begin
                n_out_data[i*uncp_pkg::OUT_W +: uncp_pkg::OUT_W] = w_mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_sq_ready) begin
            r_out_v <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sq_ready) begin
            r_out_data  <= n_out_data;
            r_out_degen <= w_sq_item.degen;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_degen;

endmodule

@@ hdl/uncp_front.sv @@
`timescale 1ns / 1ps

module uncp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [uncp_pkg::IN_DATA_W-1:0]  i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output uncp_pkg::t_div_item             o_item
);

    localparam int unsigned LAST = uncp_pkg::FRONT_STAGES - 1;

    logic [uncp_pkg::FRONT_STAGES-1:0] r_v;
    logic [uncp_pkg::FRONT_STAGES-1:0] w_rdy;

    uncp_pkg::t_coord w_a [uncp_pkg::NUM_COMP];
    uncp_pkg::t_coord w_b [uncp_pkg::NUM_COMP];

    logic signed [uncp_pkg::PROD_W-1:0]  r_p   [2*uncp_pkg::NUM_COMP];
    logic signed [uncp_pkg::CROSS_W-1:0] r_c   [uncp_pkg::NUM_COMP];
    logic signed [2*uncp_pkg::CROSS_W-1:0] w_sq [uncp_pkg::NUM_COMP];
    logic [uncp_pkg::SQ_W-1:0]           r_sq  [uncp_pkg::NUM_COMP];
    logic [uncp_pkg::NUM_COMP-1:0]       r_neg;
    logic                                r_degen;
    uncp_pkg::t_div_item                 r_item;

    always_comb begin
        for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
            w_a[i] = $signed(i_data[i*uncp_pkg::COORD_W +: uncp_pkg::COORD_W]);
            w_b[i] = $signed(i_data[(i+uncp_pkg::NUM_COMP)*uncp_pkg::COORD_W +:
                                    uncp_pkg::COORD_W]);
        end
    end

    always_comb begin
        w_rdy[LAST] = !r_v[LAST] | i_ready;
        for (int j = LAST - 1; j >= 0; j--) begin
            w_rdy[j] = !r_v[j] | w_rdy[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j <= LAST; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
            w_sq[i] = r_c[i] * r_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        // products for c = a x b
        if (w_rdy[0]) begin
            r_p[0] <= w_a[1] * w_b[2];
            r_p[1] <= w_a[2] * w_b[1];
            r_p[2] <= w_a[2] * w_b[0];
            r_p[3] <= w_a[0] * w_b[2];
            r_p[4] <= w_a[0] * w_b[1];
            r_p[5] <= w_a[1] * w_b[0];
        end
        if (w_rdy[1]) begin
            for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
                r_c[i] <= uncp_pkg::CROSS_W'(r_p[2*i]) - uncp_pkg::CROSS_W'(r_p[2*i+1]);
            end
        end
        if (w_rdy[2]) begin
            for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
                r_sq[i]  <= uncp_pkg::SQ_W'(w_sq[i]);
                r_neg[i] <= r_c[i][uncp_pkg::CROSS_W-1];
            end
            r_degen <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
        end
        if (w_rdy[3]) begin
            r_item.sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_item.neg   <= r_neg;
            r_item.degen <= r_degen;
            for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
                r_item.rem[i] <= r_sq[i];
                r_item.quo[i] <= '0;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_item  = r_item;

endmodule

@@ hdl/uncp_divider.sv @@
`timescale 1ns / 1ps

// Restoring division c^2 * 2^30 / S, one quotient bit per stage.
module uncp_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  uncp_pkg::t_div_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output uncp_pkg::t_div_item  o_item
);

    localparam int unsigned N    = uncp_pkg::DIV_STAGES;
    localparam int unsigned LAST = N - 1;

    logic [N-1:0]        r_v;
    logic [N-1:0]        w_rdy;
    uncp_pkg::t_div_item r_d [N];

    function automatic uncp_pkg::t_div_item div_step(input uncp_pkg::t_div_item x,
                                                     input logic first);
        uncp_pkg::t_div_item y;
        logic [uncp_pkg::SQ_W:0] t;
        logic [uncp_pkg::SQ_W:0] d;
        y = x;
        d = {1'b0, x.sum};
        for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
            // first stage holds the top quotient bit, no shift before it
            t = first ? {1'b0, x.rem[i]} : {x.rem[i], 1'b0};
            if (t >= d) begin
                y.rem[i] = uncp_pkg::SQ_W'(t - d);
                y.quo[i] = {x.quo[i][uncp_pkg::QUO_W-2:0], 1'b1};
            end else begin
                y.rem[i] = uncp_pkg::SQ_W'(t);
                y.quo[i] = {x.quo[i][uncp_pkg::QUO_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    always_comb begin
        w_rdy[LAST] = !r_v[LAST] | i_ready;
        for (int j = LAST - 1; j >= 0; j--) begin
            w_rdy[j] = !r_v[j] | w_rdy[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j <= LAST; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_d[0] <= div_step(i_item, 1'b1);
        end
    end

    for (genvar j = 1; j < N; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_d[j] <= div_step(r_d[j-1], 1'b0);
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_item  = r_d[LAST];

endmodule

@@ hdl/uncp_isqrt.sv @@
`timescale 1ns / 1ps

// Digit-by-digit integer square root of the quotients, one root bit per stage.
module uncp_isqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  uncp_pkg::t_div_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output uncp_pkg::t_sqrt_item o_item
);

    localparam int unsigned N    = uncp_pkg::SQRT_STAGES;
    localparam int unsigned LAST = N - 1;

    logic [N-1:0]         r_v;
    logic [N-1:0]         w_rdy;
    uncp_pkg::t_sqrt_item r_d [N];
    uncp_pkg::t_sqrt_item w_in;

    function automatic uncp_pkg::t_sqrt_item sqrt_step(input uncp_pkg::t_sqrt_item x,
                                                       input logic [uncp_pkg::ROOT_W-1:0] one);
        uncp_pkg::t_sqrt_item y;
        logic [uncp_pkg::ROOT_W-1:0] t;
        logic [uncp_pkg::ROOT_W-1:0] op;
        y = x;
        for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
            t  = x.root[i] + one;
            op = {1'b0, x.op[i]};
            if (op >= t) begin
                y.op[i]   = uncp_pkg::QUO_W'(op - t);
                y.root[i] = (x.root[i] >> 1) + one;
            end else begin
                y.root[i] = x.root[i] >> 1;
            end
        end
        return y;
    endfunction

    always_comb begin
        w_in.neg   = i_item.neg;
        w_in.degen = i_item.degen;
        for (int i = 0; i < uncp_pkg::NUM_COMP; i++) begin
            w_in.op[i]   = i_item.quo[i];
            w_in.root[i] = '0;
        end
    end

    always_comb begin
        w_rdy[LAST] = !r_v[LAST] | i_ready;
        for (int j = LAST - 1; j >= 0; j--) begin
            w_rdy[j] = !r_v[j] | w_rdy[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j <= LAST; j++) begin
                if (w_rdy[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam logic [uncp_pkg::ROOT_W-1:0] ONE =
            uncp_pkg::ROOT_W'(1) << (2 * (N - 1 - j));
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_rdy[j]) begin
                    r_d[j] <= sqrt_step(w_in, ONE);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_rdy[j]) begin
                    r_d[j] <= sqrt_step(r_d[j-1], ONE);
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_item  = r_d[LAST];

endmodule

@@ hdl/uncp_checker.sv @@
`timescale 1ns / 1ps

module uncp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [uncp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser
);

    localparam logic signed [uncp_pkg::OUT_W-1:0] LIM = 16'sd16384;

    logic signed [uncp_pkg::OUT_W-1:0] w_nx;
    logic signed [uncp_pkg::OUT_W-1:0] w_ny;
    logic signed [uncp_pkg::OUT_W-1:0] w_nz;

    assign w_nx = $signed(o_m_axis_tdata[15:0]);
    assign w_ny = $signed(o_m_axis_tdata[31:16]);
    assign w_nz = $signed(o_m_axis_tdata[47:32]);

    // a stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed under stall");

    // pipeline never backs up while the output side can drain
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_axis_tready || !o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("input stalled with output free");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("degenerate beat carries nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            (w_nx >= -LIM) && (w_nx <= LIM) && (w_ny >= -LIM) && (w_ny <= LIM) &&
            (w_nz >= -LIM) && (w_nz <= LIM) && (o_m_axis_tdata != '0))
        else $error("normal component out of range or zero vector");

endmodule

bind unit_normal_cross_product_core uncp_checker u_uncp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
